// ----- rtl/core/ioaf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ioaf_pkg
// Shared types and constants of the integer operator unit with fold.
// ----------------------------------------------------------------------------
package ioaf_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int QUEUE_DEPTH   = 2;

    // operation codes
    localparam logic [4:0] OP_ADD  = 5'd0;
    localparam logic [4:0] OP_SUB  = 5'd1;
    localparam logic [4:0] OP_RSUB = 5'd2;
    localparam logic [4:0] OP_MUL  = 5'd3;
    localparam logic [4:0] OP_DIV  = 5'd4;
    localparam logic [4:0] OP_RDIV = 5'd5;
    localparam logic [4:0] OP_MOD  = 5'd6;
    localparam logic [4:0] OP_RMOD = 5'd7;
    localparam logic [4:0] OP_OR   = 5'd8;
    localparam logic [4:0] OP_XOR  = 5'd9;
    localparam logic [4:0] OP_AND  = 5'd10;
    localparam logic [4:0] OP_SHL  = 5'd11;
    localparam logic [4:0] OP_SHR  = 5'd12;
    localparam logic [4:0] OP_SCAND = 5'd13;
    localparam logic [4:0] OP_SCOR = 5'd14;
    localparam logic [4:0] OP_MIN  = 5'd15;
    localparam logic [4:0] OP_MAX  = 5'd16;
    localparam logic [4:0] OP_EQ   = 5'd17;
    localparam logic [4:0] OP_NE   = 5'd18;
    localparam logic [4:0] OP_GT   = 5'd19;
    localparam logic [4:0] OP_LE   = 5'd20;
    localparam logic [4:0] OP_LT   = 5'd21;
    localparam logic [4:0] OP_GE   = 5'd22;
    localparam logic [4:0] OP_CMP  = 5'd23;
    localparam logic [4:0] OP_ABS  = 5'd24;
    localparam logic [4:0] OP_SQR  = 5'd25;

    // item kinds
    localparam logic [1:0] KIND_REG  = 2'd0;
    localparam logic [1:0] KIND_ITEM = 2'd1;
    localparam logic [1:0] KIND_FOLD = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    localparam int CFG_OPCODE = 0;
    localparam int CFG_RIGHT  = 1;

endpackage
`default_nettype wire

// ----- rtl/core/ioaf_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ioaf_front
// Accepts input requests, drops unused kinds and queues classified requests.
// ----------------------------------------------------------------------------
module ioaf_front #(
    parameter int WORD_BITS = ioaf_pkg::WORD_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [1:0]           i_kind,
    input  wire logic [WORD_BITS-1:0] i_a,
    input  wire logic [WORD_BITS-1:0] i_b,
    input  wire logic                 i_first,
    input  wire logic                 i_last,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic                      o_fold,
    output logic [WORD_BITS-1:0]      o_a,
    output logic [WORD_BITS-1:0]      o_b,
    output logic                      o_first,
    output logic                      o_last
);
    localparam int D = ioaf_pkg::QUEUE_DEPTH;
    localparam int PW = $clog2(D);

    typedef struct packed {
        logic                 fold;
        logic [WORD_BITS-1:0] a;
        logic [WORD_BITS-1:0] b;
        logic                 first;
        logic                 last;
    } t_req;

    t_req            r_mem [D];
    logic [PW-1:0]   r_wp, r_rp;
    logic [PW:0]     r_cnt;
    logic            push, pop, keep;
    t_req            w;

    assign o_ready = (r_cnt != (PW+1)'(D));
    assign keep    = (i_kind != ioaf_pkg::KIND_NONE);
    assign push    = i_valid && o_ready && keep;
    assign pop     = o_valid && i_ready;
    assign o_valid = (r_cnt != '0);

    // request classification
    always_comb begin
        w.fold  = (i_kind == ioaf_pkg::KIND_FOLD);
        w.a     = i_a;
        w.b     = i_b;
        w.first = i_first;
        w.last  = i_last;
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= (r_wp == PW'(D-1)) ? '0 : r_wp + 1'b1;
            if (pop)  r_rp <= (r_rp == PW'(D-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= w;
    end

    assign o_fold  = r_mem[r_rp].fold;
    assign o_a     = r_mem[r_rp].a;
    assign o_b     = r_mem[r_rp].b;
    assign o_first = r_mem[r_rp].first;
    assign o_last  = r_mem[r_rp].last;
endmodule
`default_nettype wire

// ----- rtl/core/ioaf_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ioaf_back
// Carries out one queued request: operand select, operation, fold update.
// Division runs one quotient bit per cycle on a shared restoring divider.
// ----------------------------------------------------------------------------
module ioaf_back #(
    parameter int WORD_BITS = ioaf_pkg::WORD_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [4:0]           i_opcode,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic                 i_fold,
    input  wire logic [WORD_BITS-1:0] i_a,
    input  wire logic [WORD_BITS-1:0] i_b,
    input  wire logic                 i_first,
    input  wire logic                 i_last,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [WORD_BITS-1:0]      o_result
);
    localparam int W  = WORD_BITS;
    localparam int CW = $clog2(W + 1);
    localparam int SW = $clog2(W);

    typedef enum logic [2:0] {S_IDLE, S_EXEC, S_MUL, S_DIV, S_DONE, S_OUT} t_state;

    t_state          r_state;
    logic [W-1:0]    r_x, r_y, r_acc, r_res, r_out;
    logic            r_fold, r_last, r_ovalid;
    logic [W-1:0]    r_dq, r_dr, r_dd;
    logic            r_qneg, r_rneg, r_is_mod;
    logic [CW-1:0]   r_cnt;
    logic [2*W-1:0]  r_prod;

    logic [W-1:0]    x, y, ma, mb, simple;
    logic            lt_xy, lt_yx, is_div;
    logic [SW-1:0]   sh;
    logic [W:0]      trial;
    logic [W-1:0]    rshift;
    logic            out_load;

    assign o_valid  = r_ovalid;
    assign o_result = r_out;
    assign o_ready  = (r_state == S_IDLE);
    assign out_load = (r_state == S_OUT) && (!r_ovalid || i_ready);

    // operand select for the current request
    always_comb begin
        x = i_fold ? (i_first ? i_a : r_acc) : i_a;
        y = i_b;
    end

    // combinational operations on registered operands
    always_comb begin
        lt_xy  = $signed(r_x) < $signed(r_y);
        lt_yx  = $signed(r_y) < $signed(r_x);
        sh     = r_y[SW-1:0];
        rshift = W'($signed(r_x) >>> sh);
        ma     = r_x[W-1] ? W'(0) - r_x : r_x;
        case (i_opcode)
            ioaf_pkg::OP_ADD:   simple = r_x + r_y;
            ioaf_pkg::OP_SUB:   simple = r_x - r_y;
            ioaf_pkg::OP_RSUB:  simple = r_y - r_x;
            ioaf_pkg::OP_OR:    simple = r_x | r_y;
            ioaf_pkg::OP_XOR:   simple = r_x ^ r_y;
            ioaf_pkg::OP_AND:   simple = r_x & r_y;
            ioaf_pkg::OP_SHL:   simple = r_x << sh;
            ioaf_pkg::OP_SHR:   simple = rshift;
            ioaf_pkg::OP_SCAND: simple = (r_x != '0) ? r_y : '0;
            ioaf_pkg::OP_SCOR:  simple = (r_x != '0) ? r_x : r_y;
            ioaf_pkg::OP_MIN:   simple = lt_yx ? r_y : r_x;
            ioaf_pkg::OP_MAX:   simple = lt_xy ? r_y : r_x;
            ioaf_pkg::OP_EQ:    simple = W'(r_x == r_y);
            ioaf_pkg::OP_NE:    simple = W'(r_x != r_y);
            ioaf_pkg::OP_GT:    simple = W'(lt_yx);
            ioaf_pkg::OP_LE:    simple = W'(!lt_yx);
            ioaf_pkg::OP_LT:    simple = W'(lt_xy);
            ioaf_pkg::OP_GE:    simple = W'(!lt_xy);
            ioaf_pkg::OP_CMP:   simple = lt_xy ? '1 : W'(lt_yx);
            ioaf_pkg::OP_ABS:   simple = ma;
            default:            simple = '0;
        endcase
    end

    // divider set-up: dividend and divisor after reverse swap
    logic [W-1:0] dn, dv;
    always_comb begin
        is_div = (i_opcode == ioaf_pkg::OP_DIV) || (i_opcode == ioaf_pkg::OP_RDIV)
              || (i_opcode == ioaf_pkg::OP_MOD) || (i_opcode == ioaf_pkg::OP_RMOD);
        if ((i_opcode == ioaf_pkg::OP_RDIV) || (i_opcode == ioaf_pkg::OP_RMOD)) begin
            dn = r_y; dv = r_x;
        end else begin
            dn = r_x; dv = r_y;
        end
        mb    = dv[W-1] ? W'(0) - dv : dv;
        trial = {r_dr, r_dq[W-1]} - {1'b0, r_dd};
    end

    // sequencer, datapath registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_acc    <= '0;
        end else begin
            if (out_load)                 r_ovalid <= 1'b1;
            else if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_x     <= x;
                        r_y     <= y;
                        r_fold  <= i_fold;
                        r_last  <= i_last;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if ((i_opcode == ioaf_pkg::OP_MUL) || (i_opcode == ioaf_pkg::OP_SQR)) begin
                        r_prod  <= r_x * ((i_opcode == ioaf_pkg::OP_SQR) ? r_x : r_y);
                        r_state <= S_MUL;
                    end else if (is_div) begin
                        if (dv == '0) begin
                            r_res   <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_dq     <= dn[W-1] ? W'(0) - dn : dn;
                            r_dd     <= mb;
                            r_dr     <= '0;
                            r_qneg   <= dn[W-1] ^ dv[W-1];
                            r_rneg   <= dn[W-1];
                            r_is_mod <= (i_opcode == ioaf_pkg::OP_MOD)
                                     || (i_opcode == ioaf_pkg::OP_RMOD);
                            r_cnt    <= CW'(W);
                            r_state  <= S_DIV;
                        end
                    end else begin
                        r_res   <= simple;
                        r_state <= S_DONE;
                    end
                end
                S_MUL: begin
                    r_res   <= r_prod[W-1:0];
                    r_state <= S_DONE;
                end
                S_DIV: begin
                    if (r_cnt == '0) begin
                        if (r_is_mod) r_res <= r_rneg ? W'(0) - r_dr : r_dr;
                        else          r_res <= r_qneg ? W'(0) - r_dq : r_dq;
                        r_state <= S_DONE;
                    end else begin
                        if (!trial[W]) begin
                            r_dr <= trial[W-1:0];
                            r_dq <= {r_dq[W-2:0], 1'b1};
                        end else begin
                            r_dr <= {r_dr[W-2:0], r_dq[W-1]};
                            r_dq <= {r_dq[W-2:0], 1'b0};
                        end
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_DONE: begin
                    if (r_fold) r_acc <= r_res;
                    if (!r_fold || r_last) r_state <= S_OUT;
                    else                   r_state <= S_IDLE;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/integer_operator_alu_with_fold_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// integer_operator_alu_with_fold_core
// Signed operator unit with element-wise and fold modes.
// ----------------------------------------------------------------------------
// A request is taken into a two-entry queue, then executed one at a time.
// The back end registers the operands; simple operations then write the
// result, multiply and square pass through a product register, and divide
// or modulo run the bit-serial divider (skipped when the divisor is zero).
// The back end takes no new request until it is done with the last one; a
// fold step without last gives no result and skips the output register.
// A stalled result holds the back end, and the input stalls once the queue
// is full. Requests of kind 3 are dropped in the front without any result.
module integer_operator_alu_with_fold_core #(
    parameter int WORD_BITS = ioaf_pkg::WORD_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: a_value[31:0], b_value[63:32]
    input  wire logic [63:0] s_axis_tdata,
    // tuser: kind[1:0], first[2]
    input  wire logic [2:0]  s_axis_tuser,
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: result[31:0]
    output logic [31:0]      m_axis_tdata
);
    localparam int W = WORD_BITS;

    logic [4:0]  r_opcode;
    logic [31:0] r_right;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opcode <= ioaf_pkg::OP_ADD;
            r_right  <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == 1'(ioaf_pkg::CFG_OPCODE)) r_opcode <= i_cfg_data[4:0];
            else                                           r_right  <= i_cfg_data;
        end
    end

    logic [1:0]  kind;
    logic [W-1:0] a_ext, b_ext, r_ext;
    assign kind  = s_axis_tuser[1:0];
    assign a_ext = W'($signed(s_axis_tdata[31:0]));
    assign r_ext = W'($signed(r_right));
    // element with register operand takes the configured value
    assign b_ext = (kind == ioaf_pkg::KIND_REG) ? r_ext : W'($signed(s_axis_tdata[63:32]));

    logic q_valid, q_ready, q_fold, q_first, q_last;
    logic [W-1:0] q_a, q_b, res;

    ioaf_front #(.WORD_BITS(W)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_kind(kind), .i_a(a_ext), .i_b(b_ext),
        .i_first(s_axis_tuser[2]), .i_last(s_axis_tlast),
        .o_valid(q_valid), .i_ready(q_ready),
        .o_fold(q_fold), .o_a(q_a), .o_b(q_b), .o_first(q_first), .o_last(q_last)
    );

    ioaf_back #(.WORD_BITS(W)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_opcode(r_opcode),
        .i_valid(q_valid), .o_ready(q_ready),
        .i_fold(q_fold), .i_a(q_a), .i_b(q_b), .i_first(q_first), .i_last(q_last),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_result(res)
    );

    assign m_axis_tdata = 32'(res);
endmodule
`default_nettype wire

// ----- test/integer_operator_alu_with_fold_core_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// integer_operator_alu_with_fold_core_tb
// Self-checking bench for the operator unit: directed edge cases from a
// table, then random element and fold requests with random stalls on both
// sides, all results compared against a behavioural predictor in order.
// ----------------------------------------------------------------------------
module integer_operator_alu_with_fold_core_tb;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] a;
        logic [31:0] b;
        logic        first;
        logic        last;
    } t_alu_req;

    // directed row: opcode, register operand, request, optional typed result
    typedef struct {
        logic [4:0]  op;
        logic [31:0] rop;
        t_alu_req    req;
        bit          fixed;
        logic [31:0] res;
    } t_dir_row;

    localparam logic [31:0] MIN_INT = 32'h8000_0000;
    localparam logic [31:0] MAX_INT = 32'h7fff_ffff;
    localparam logic [31:0] NEG_ONE = 32'hffff_ffff;
    localparam int          LIMIT   = 1_000_000;
    localparam int          N_RAND  = 1350;

    // model copy of the block's state
    logic [4:0]  mdl_op;
    logic [31:0] mdl_rop;
    logic [31:0] mdl_acc;

    logic [31:0] result_q[$];
    int          errors;
    int          cycles = 0;

    integer_operator_alu_with_fold_core dut (.*);

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAIL integer_operator_alu_with_fold_core");
            $finish;
        end
    end

    function automatic logic [31:0] op_result(logic [4:0] op, logic [31:0] a,
                                              logic [31:0] b);
        logic signed [31:0] sa;
        logic signed [31:0] sb;
        logic [31:0]        r;
        sa = a;
        sb = b;
        r  = '0;
        case (op)
            ioaf_pkg::OP_ADD:   r = a + b;
            ioaf_pkg::OP_SUB:   r = a - b;
            ioaf_pkg::OP_RSUB:  r = b - a;
            ioaf_pkg::OP_MUL:   r = a * b;
            ioaf_pkg::OP_DIV:   r = (b == 0) ? 0 : ((a == MIN_INT && b == NEG_ONE)
                                    ? $signed(MIN_INT) : sa / sb);
            ioaf_pkg::OP_RDIV:  r = (a == 0) ? 0 : ((b == MIN_INT && a == NEG_ONE)
                                    ? $signed(MIN_INT) : sb / sa);
            ioaf_pkg::OP_MOD:   r = (b == 0 || b == NEG_ONE) ? 0 : sa % sb;
            ioaf_pkg::OP_RMOD:  r = (a == 0 || a == NEG_ONE) ? 0 : sb % sa;
            ioaf_pkg::OP_OR:    r = a | b;
            ioaf_pkg::OP_XOR:   r = a ^ b;
            ioaf_pkg::OP_AND:   r = a & b;
            ioaf_pkg::OP_SHL:   r = a << b[4:0];
            ioaf_pkg::OP_SHR:   r = sa >>> b[4:0];
            ioaf_pkg::OP_SCAND: r = (a != 0) ? b : 0;
            ioaf_pkg::OP_SCOR:  r = (a != 0) ? a : b;
            ioaf_pkg::OP_MIN:   r = (sb < sa) ? b : a;
            ioaf_pkg::OP_MAX:   r = (sa < sb) ? b : a;
            ioaf_pkg::OP_EQ:    r = 32'(a == b);
            ioaf_pkg::OP_NE:    r = 32'(a != b);
            ioaf_pkg::OP_GT:    r = 32'(sa > sb);
            ioaf_pkg::OP_LE:    r = 32'(sa <= sb);
            ioaf_pkg::OP_LT:    r = 32'(sa < sb);
            ioaf_pkg::OP_GE:    r = 32'(sa >= sb);
            ioaf_pkg::OP_CMP:   r = (sa < sb) ? NEG_ONE : ((sa > sb) ? 32'd1 : 32'd0);
            ioaf_pkg::OP_ABS:   r = sa[31] ? -a : a;
            ioaf_pkg::OP_SQR:   r = a * a;
            default:            r = '0;
        endcase
        return r;
    endfunction

    // queue the expected result of one accepted request
    task automatic predict_request(t_alu_req rq);
        case (rq.kind)
            ioaf_pkg::KIND_REG:  result_q.push_back(op_result(mdl_op, rq.a, mdl_rop));
            ioaf_pkg::KIND_ITEM: result_q.push_back(op_result(mdl_op, rq.a, rq.b));
            ioaf_pkg::KIND_FOLD: begin
                if (rq.first) mdl_acc = rq.a;
                mdl_acc = op_result(mdl_op, mdl_acc, rq.b);
                if (rq.last) result_q.push_back(mdl_acc);
            end
            default: ;
        endcase
    endtask

    // result checker with random back-pressure
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (result_q.size() == 0) begin
                $error("result 0x%08h with nothing expected", m_axis_tdata);
                errors <= errors + 1;
            end else begin
                if (m_axis_tdata !== result_q[0]) begin
                    $error("result: expected 0x%08h, got 0x%08h", result_q[0], m_axis_tdata);
                    errors <= errors + 1;
                end
                void'(result_q.pop_front());
            end
        end
        if ($urandom_range(0, 9) < 7) m_axis_tready <= 1'b1;
        else if ($urandom_range(0, 19) == 0) m_axis_tready <= 1'b0;
        else m_axis_tready <= ($urandom_range(0, 1) == 1);
    end

    task automatic write_reg(logic [0:0] idx, logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == 1'(ioaf_pkg::CFG_OPCODE)) mdl_op = val[4:0];
        else mdl_rop = val;
    endtask

    // let the block go idle before touching a register
    task automatic drain();
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic send_request(t_alu_req rq);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rq.b, rq.a};
        s_axis_tuser  <= {rq.first, rq.kind};
        s_axis_tlast  <= rq.last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_request(rq);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return MIN_INT;
            1: return MAX_INT;
            2: return NEG_ONE;
            3: return 32'($urandom_range(0, 3));
            4: return 32'($urandom_range(0, 63)) - 32'd32;
            default: return $urandom;
        endcase
    endfunction

    t_dir_row   dir_rows[$];
    t_alu_req   rq;
    logic [4:0] pick_op;
    int         fold_len;

    initial begin
        errors        = 0;
        mdl_op        = ioaf_pkg::OP_ADD;
        mdl_rop       = '0;
        mdl_acc       = '0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;

        // directed cases; rows with fixed set carry a hand-typed result
        dir_rows = '{
            '{ioaf_pkg::OP_ADD,  32'd0,
              '{ioaf_pkg::KIND_REG,  32'd5,   32'd0,   1'b0, 1'b0}, 1, 32'd5},
            '{ioaf_pkg::OP_ADD,  32'd0,
              '{ioaf_pkg::KIND_ITEM, MAX_INT, 32'd1,   1'b1, 1'b1}, 1, MIN_INT},
            '{ioaf_pkg::OP_DIV,  32'd0,
              '{ioaf_pkg::KIND_REG,  32'd7,   32'd0,   1'b0, 1'b0}, 1, 32'd0},
            '{ioaf_pkg::OP_DIV,  32'd0,
              '{ioaf_pkg::KIND_ITEM, MIN_INT, NEG_ONE, 1'b0, 1'b0}, 1, MIN_INT},
            '{ioaf_pkg::OP_MOD,  32'd0,
              '{ioaf_pkg::KIND_ITEM, MIN_INT, NEG_ONE, 1'b0, 1'b0}, 1, 32'd0},
            '{ioaf_pkg::OP_MOD,  32'd0,
              '{ioaf_pkg::KIND_ITEM, 32'd9,   32'd0,   1'b0, 1'b0}, 1, 32'd0},
            '{ioaf_pkg::OP_RDIV, 32'd0,
              '{ioaf_pkg::KIND_ITEM, 32'd0,   32'd9,   1'b0, 1'b0}, 1, 32'd0},
            '{ioaf_pkg::OP_RMOD, 32'd0,
              '{ioaf_pkg::KIND_ITEM, NEG_ONE, MIN_INT, 1'b0, 1'b0}, 1, 32'd0},
            '{ioaf_pkg::OP_RDIV, 32'd0,
              '{ioaf_pkg::KIND_ITEM, NEG_ONE, MIN_INT, 1'b0, 1'b0}, 1, MIN_INT},
            '{ioaf_pkg::OP_SHL,  32'd33,
              '{ioaf_pkg::KIND_REG,  32'd1,   32'd0,   1'b0, 1'b0}, 1, 32'd2},
            '{ioaf_pkg::OP_SHR,  32'd0,
              '{ioaf_pkg::KIND_ITEM, MIN_INT, 32'd63,  1'b0, 1'b0}, 1, NEG_ONE},
            '{ioaf_pkg::OP_ABS,  32'd0,
              '{ioaf_pkg::KIND_ITEM, MIN_INT, 32'd3,   1'b0, 1'b0}, 1, MIN_INT},
            '{ioaf_pkg::OP_SQR,  NEG_ONE,
              '{ioaf_pkg::KIND_REG,  MAX_INT, 32'd0,   1'b0, 1'b0}, 1, 32'd1},
            '{ioaf_pkg::OP_CMP,  MAX_INT,
              '{ioaf_pkg::KIND_REG,  MIN_INT, 32'd0,   1'b0, 1'b0}, 1, NEG_ONE},
            '{5'd31,             32'd0,
              '{ioaf_pkg::KIND_ITEM, 32'd4,   32'd5,   1'b0, 1'b0}, 1, 32'd0},
            '{ioaf_pkg::OP_ADD,  32'd0,
              '{ioaf_pkg::KIND_NONE, 32'd4,   32'd5,   1'b1, 1'b1}, 0, 32'd0},
            '{ioaf_pkg::OP_MAX,  32'd0,
              '{ioaf_pkg::KIND_FOLD, MIN_INT, 32'd3,   1'b1, 1'b0}, 0, 32'd0},
            '{ioaf_pkg::OP_MAX,  32'd0,
              '{ioaf_pkg::KIND_FOLD, 32'd0,   MAX_INT, 1'b0, 1'b1}, 1, MAX_INT},
            '{ioaf_pkg::OP_ABS,  32'd0,
              '{ioaf_pkg::KIND_FOLD, NEG_ONE, 32'd9,   1'b1, 1'b1}, 1, 32'd1},
            '{ioaf_pkg::OP_SCAND, 32'd0,
              '{ioaf_pkg::KIND_ITEM, 32'd0,   32'd8,   1'b0, 1'b0}, 1, 32'd0},
            '{ioaf_pkg::OP_SCOR, 32'd0,
              '{ioaf_pkg::KIND_ITEM, 32'd0,   32'd8,   1'b0, 1'b0}, 1, 32'd8},
            '{ioaf_pkg::OP_MIN,  32'd0,
              '{ioaf_pkg::KIND_ITEM, MIN_INT, MAX_INT, 1'b0, 1'b0}, 1, MIN_INT},
            '{ioaf_pkg::OP_RSUB, 32'd0,
              '{ioaf_pkg::KIND_ITEM, 32'd1,   MIN_INT, 1'b0, 1'b0}, 1, MAX_INT}
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // request with kind 0 straight after reset uses reset registers
        rq = t_alu_req'{ioaf_pkg::KIND_REG, 32'hdead_beef, 32'd1, 1'b0, 1'b0};
        send_request(rq);
        s_axis_tvalid <= 1'b0;

        foreach (dir_rows[i]) begin
            drain();
            write_reg(1'(ioaf_pkg::CFG_OPCODE), 32'(dir_rows[i].op));
            write_reg(1'(ioaf_pkg::CFG_RIGHT), dir_rows[i].rop);
            send_request(dir_rows[i].req);
            s_axis_tvalid <= 1'b0;
            if (dir_rows[i].fixed && result_q.size() != 0
                && result_q[$] !== dir_rows[i].res) begin
                $error("table result: expected 0x%08h, predicted 0x%08h",
                       dir_rows[i].res, result_q[$]);
                errors++;
            end
        end

        // random phases: new registers, then a burst of requests
        for (int n = 0; n < N_RAND; ) begin
            drain();
            pick_op = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(26, 31))
                                                    : 5'($urandom_range(0, 25));
            write_reg(1'(ioaf_pkg::CFG_OPCODE), 32'(pick_op));
            write_reg(1'(ioaf_pkg::CFG_RIGHT), rand_word());
            for (int k = 0; k < 30 && n < N_RAND; ) begin
                if ($urandom_range(0, 2) == 0) begin
                    // well-formed fold run
                    fold_len = $urandom_range(1, 5);
                    for (int f = 0; f < fold_len; f++) begin
                        rq = t_alu_req'{ioaf_pkg::KIND_FOLD, rand_word(), rand_word(),
                                        f == 0, f == fold_len - 1};
                        send_request(rq);
                    end
                    k += fold_len;
                    n += fold_len;
                end else begin
                    rq = t_alu_req'{2'($urandom_range(0, 2)), rand_word(), rand_word(),
                                    1'($urandom), 1'($urandom)};
                    if ($urandom_range(0, 30) == 0) rq.kind = ioaf_pkg::KIND_NONE;
                    send_request(rq);
                    if (rq.kind != ioaf_pkg::KIND_NONE) begin
                        k++;
                        n++;
                    end
                end
            end
            s_axis_tvalid <= 1'b0;
        end

        s_axis_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0 && result_q.size() == 0) begin
            $display("PASS integer_operator_alu_with_fold_core");
        end else begin
            $display("FAIL integer_operator_alu_with_fold_core");
        end
        $finish;
    end
endmodule
`default_nettype wire
